// ===== hdl/mcs_pkg.sv =====
// ============================================================================
// mcs_pkg
// Shared types, constants, microcode program and helpers of the motion
// command serializer.
// ============================================================================
`default_nettype none

package mcs_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int FIELD_W   = 11;
    localparam int ENTRY_W   = 2 * FIELD_W;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int MAG_W     = 14;
    localparam int DIG_W     = 10;
    localparam int SPDQ_W    = 7;
    localparam int PC_W      = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CEILING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP_MM   = 3'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] TURN_SPEED_RST    = 10'd45;
    localparam logic [CFG_W-1:0] SPEED_FLOOR_RST   = 10'd20;
    localparam logic [CFG_W-1:0] SPEED_CEILING_RST = 10'd200;
    localparam logic [CFG_W-1:0] MAX_STEP_MM_RST   = 10'd999;

    localparam logic [DIG_W-1:0] DIG_MAX = 10'd999;

    // ASCII codes
    localparam logic [7:0] ASCII_R    = 8'h72;
    localparam logic [7:0] ASCII_L    = 8'h6C;
    localparam logic [7:0] ASCII_M    = 8'h6D;
    localparam logic [7:0] ASCII_F    = 8'h66;
    localparam logic [7:0] ASCII_B    = 8'h62;
    localparam logic [7:0] ASCII_NL   = 8'h0A;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // Program addresses
    localparam logic [PC_W-1:0] PC_IDLE    = 5'd0;
    localparam logic [PC_W-1:0] PC_LOAD    = 5'd1;
    localparam logic [PC_W-1:0] PC_CALC    = 5'd2;
    localparam logic [PC_W-1:0] PC_ROT     = 5'd3;
    localparam logic [PC_W-1:0] PC_ROT_NL  = 5'd14;
    localparam logic [PC_W-1:0] PC_MOV_CHK = 5'd15;
    localparam logic [PC_W-1:0] PC_MOV     = 5'd16;
    localparam logic [PC_W-1:0] PC_MOV_NL  = 5'd27;
    localparam logic [PC_W-1:0] PC_SPLIT   = 5'd28;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_CALC,
        OP_EMIT,
        OP_NOP,
        OP_SPLIT
    } op_t;

    typedef enum logic [2:0] {
        BYTE_R,
        BYTE_M,
        BYTE_ROTDIR,
        BYTE_MOVDIR,
        BYTE_HUND,
        BYTE_TENS,
        BYTE_ONES,
        BYTE_NL
    } byte_sel_t;

    typedef enum logic [2:0] {
        DIG_HOLD,
        DIG_HUND,
        DIG_TENS,
        DIG_TURN,
        DIG_ROT,
        DIG_SPD,
        DIG_MOV
    } dig_sel_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_ROT_ZERO,
        COND_MOV_ZERO,
        COND_SPLIT_DONE
    } cond_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_IF_NO_MOVE
    } last_sel_t;

    typedef struct packed {
        op_t              op;
        byte_sel_t        bsel;
        dig_sel_t         dsel;
        cond_t            cond;
        logic             rpt;   // stay on this word while the condition is false
        logic [PC_W-1:0]  jmp;
        last_sel_t        last;
    } ctrl_word_t;

    // Microcode ROM
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w.op   = OP_NOP;
        w.bsel = BYTE_NL;
        w.dsel = DIG_HOLD;
        w.cond = COND_NEVER;
        w.rpt  = 1'b0;
        w.jmp  = PC_IDLE;
        w.last = LAST_NO;
        unique case (pc)
            PC_IDLE: begin
                w.op  = OP_IDLE;
                w.jmp = PC_SPLIT;
            end
            PC_LOAD: w.op = OP_LOAD;
            PC_CALC: begin
                w.op   = OP_CALC;
                w.cond = COND_ROT_ZERO;
                w.jmp  = PC_MOV_CHK;
            end
            PC_ROT: begin
                w.op   = OP_EMIT;
                w.bsel = BYTE_R;
                w.dsel = DIG_TURN;
            end
            5'd4: begin
                w.op   = OP_EMIT;
                w.bsel = BYTE_ROTDIR;
            end
            5'd5, 5'd8, 5'd11, 5'd18, 5'd21, 5'd24: begin
                w.op   = OP_EMIT;
                w.bsel = BYTE_HUND;
                w.dsel = DIG_HUND;
            end
            5'd6, 5'd9, 5'd12, 5'd19, 5'd22, 5'd25: begin
                w.op   = OP_EMIT;
                w.bsel = BYTE_TENS;
                w.dsel = DIG_TENS;
            end
            5'd7, 5'd10: begin
                w.op   = OP_EMIT;
                w.bsel = BYTE_ONES;
                w.dsel = DIG_ROT;
            end
            5'd13, 5'd26: begin
                w.op   = OP_EMIT;
                w.bsel = BYTE_ONES;
            end
            PC_ROT_NL: begin
                w.op   = OP_EMIT;
                w.bsel = BYTE_NL;
                w.cond = COND_MOV_ZERO;
                w.last = LAST_IF_NO_MOVE;
            end
            PC_MOV_CHK: begin
                w.op   = OP_NOP;
                w.cond = COND_MOV_ZERO;
            end
            PC_MOV: begin
                w.op   = OP_EMIT;
                w.bsel = BYTE_M;
                w.dsel = DIG_SPD;
            end
            5'd17: begin
                w.op   = OP_EMIT;
                w.bsel = BYTE_MOVDIR;
            end
            5'd20, 5'd23: begin
                w.op   = OP_EMIT;
                w.bsel = BYTE_ONES;
                w.dsel = DIG_MOV;
            end
            PC_MOV_NL: begin
                w.op   = OP_EMIT;
                w.bsel = BYTE_NL;
                w.cond = COND_ALWAYS;
                w.last = LAST_YES;
            end
            PC_SPLIT: begin
                w.op   = OP_SPLIT;
                w.cond = COND_SPLIT_DONE;
                w.rpt  = 1'b1;
            end
            default: begin
                w.op   = OP_NOP;
                w.cond = COND_ALWAYS;
            end
        endcase
        return w;
    endfunction

    function automatic logic [DIG_W-1:0] cap999(input logic [FIELD_W-1:0] v);
        return (v > FIELD_W'(DIG_MAX)) ? DIG_MAX : v[DIG_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] abs11(input logic [FIELD_W-1:0] v);
        return v[FIELD_W-1] ? FIELD_W'(-v) : v;
    endfunction

    // Hundreds digit of a value up to 999
    function automatic logic [3:0] hund_digit(input logic [DIG_W-1:0] v);
        logic [3:0] d;
        d = 4'd0;
        for (int i = 1; i <= 9; i++) begin
            if (v >= DIG_W'(i * 100)) d = 4'(i);
        end
        return d;
    endfunction

    // Tens digit of a value below 100
    function automatic logic [3:0] tens_digit(input logic [DIG_W-1:0] v);
        logic [3:0] d;
        d = 4'd0;
        for (int i = 1; i <= 9; i++) begin
            if (v >= DIG_W'(i * 10)) d = 4'(i);
        end
        return d;
    endfunction

    function automatic logic [QIDX_W-1:0] next_idx(input logic [QIDX_W-1:0] idx);
        return (idx == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : QIDX_W'(idx + 1'b1);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mcs_ram.sv =====
// ============================================================================
// mcs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module mcs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/motion_command_serializer_core.sv =====
// ============================================================================
// motion_command_serializer_core
// Queues path elements as split movement/rotation steps and serializes one
// step per tick into ASCII rotation and movement commands.
// ============================================================================
//
//  channel | ports                                        | dir | role
//  --------+----------------------------------------------+-----+-----------------
//  s_      | s_valid/s_ready, command, distance, angle,   | in  | elements, ticks
//          | first_of_message                             |     |
//  m_      | m_valid/m_ready, m_out_byte, m_last_byte     | out | command bytes
//  cfg_    | cfg_valid/cfg_ready, cfg_index, cfg_data     | in  | register writes
//
//  A path element is split into queued steps; any steps left over when the
//  queue fills are dropped. A tick emits up to 24 command bytes; a tick
//  on an empty queue emits none.
//  Reset is synchronous and clears the queue pointers, the sequencer and the
//  configuration registers to their defaults; no clearing pass is needed.
//  A stalled m_ready holds the sequencer on its current byte step.
//
`default_nettype none

module motion_command_serializer_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // path element / tick channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_command,
    input  wire logic signed [mcs_pkg::FIELD_W-1:0] s_distance_cm,
    input  wire logic signed [mcs_pkg::FIELD_W-1:0] s_turn_angle,
    input  wire logic                               s_first_of_message,
    // byte channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [7:0]                              m_out_byte,
    output logic                                    m_last_byte,
    // configuration channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mcs_pkg::CFG_W-1:0]          cfg_data
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [mcs_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic [mcs_pkg::QIDX_W-1:0]  head_reg, head_next;
    logic [mcs_pkg::QIDX_W-1:0]  tail_reg, tail_next;
    logic [mcs_pkg::QCNT_W-1:0]  count_reg, count_next;

    logic [mcs_pkg::CFG_W-1:0]   turn_speed_reg, turn_speed_next;
    logic [mcs_pkg::CFG_W-1:0]   speed_floor_reg, speed_floor_next;
    logic [mcs_pkg::CFG_W-1:0]   speed_ceiling_reg, speed_ceiling_next;
    logic [mcs_pkg::CFG_W-1:0]   max_step_reg, max_step_next;

    logic [mcs_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic [mcs_pkg::DIG_W-1:0]   step_reg, step_next;
    logic                        neg_reg, neg_next;
    logic [mcs_pkg::FIELD_W-1:0] ang_reg, ang_next;
    logic [mcs_pkg::FIELD_W-1:0] mov_reg, mov_next;
    logic [mcs_pkg::FIELD_W-1:0] rot_reg, rot_next;
    logic [mcs_pkg::SPDQ_W-1:0]  spd_q_reg, spd_q_next;
    logic [mcs_pkg::DIG_W-1:0]   dig_reg, dig_next;

    logic                        m_valid_reg, m_valid_next;
    logic [7:0]                  m_out_byte_reg, m_out_byte_next;
    logic                        m_last_byte_reg, m_last_byte_next;

    // ------------------------------------------------------------------
    // Datapath signals
    // ------------------------------------------------------------------
    mcs_pkg::ctrl_word_t         cw;
    logic                        s_accept;
    logic                        cfg_accept;
    logic                        out_free;
    logic                        is_stop;
    logic                        q_full;
    logic                        q_empty;
    logic                        mov_zero;
    logic                        rot_zero;
    logic                        split_more;
    logic                        split_done;
    logic                        cond_true;
    logic                        step_ok;
    logic [mcs_pkg::FIELD_W-1:0] dist_abs;
    logic [mcs_pkg::DIG_W-1:0]   mov_mag;
    logic [mcs_pkg::DIG_W-1:0]   rot_mag;
    logic [mcs_pkg::DIG_W-1:0]   spd_clamped;
    logic [17:0]                 spd_prod;
    logic [3:0]                  hd;
    logic [3:0]                  td;
    logic [7:0]                  emit_byte;
    logic                        emit_last;
    logic [mcs_pkg::FIELD_W-1:0] push_mag;
    logic [mcs_pkg::FIELD_W-1:0] push_mov;
    logic [mcs_pkg::FIELD_W-1:0] push_rot;
    logic                        ram_we;
    logic [mcs_pkg::ENTRY_W-1:0] ram_rdata;

    assign cw         = mcs_pkg::ucode(pc_reg);
    assign s_ready    = (pc_reg == mcs_pkg::PC_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_last_byte = m_last_byte_reg;

    assign is_stop = s_first_of_message && (s_distance_cm == '0) && (s_turn_angle == '0);
    assign q_full  = (count_reg == mcs_pkg::QCNT_W'(mcs_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);

    assign mov_zero = (mov_reg == '0);
    assign rot_zero = (rot_reg == '0);

    assign split_more = (mag_reg > mcs_pkg::MAG_W'(step_reg));
    assign split_done = q_full || !split_more;

    assign dist_abs = mcs_pkg::abs11(s_distance_cm);
    assign mov_mag  = mcs_pkg::cap999(mcs_pkg::abs11(mov_reg));
    assign rot_mag  = mcs_pkg::cap999(mcs_pkg::abs11(rot_reg));

    // m / 10 as a reciprocal multiply, exact for m below 1024
    assign spd_prod = 18'(mov_mag) * 18'd205;

    always_comb begin
        logic [mcs_pkg::DIG_W-1:0] spd;
        spd = mcs_pkg::DIG_W'(spd_q_reg);
        priority if (spd < speed_floor_reg) begin
            spd = speed_floor_reg;
        end else if (spd > speed_ceiling_reg) begin
            spd = speed_ceiling_reg;
        end
        spd_clamped = mcs_pkg::cap999({1'b0, spd});
    end

    assign hd = mcs_pkg::hund_digit(dig_reg);
    assign td = mcs_pkg::tens_digit(dig_reg);

    // Step pushed by the split loop: full step length, or the remainder with the angle
    assign push_mag = split_more ? {1'b0, step_reg} : mag_reg[mcs_pkg::FIELD_W-1:0];
    assign push_mov = neg_reg ? mcs_pkg::FIELD_W'(-push_mag) : push_mag;
    assign push_rot = split_more ? '0 : ang_reg;
    assign ram_we   = (cw.op == mcs_pkg::OP_SPLIT) && !q_full;

    mcs_ram #(
        .WIDTH (mcs_pkg::ENTRY_W),
        .DEPTH (mcs_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata ({push_rot, push_mov}),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Byte source
    always_comb begin
        unique case (cw.bsel)
            mcs_pkg::BYTE_R:      emit_byte = mcs_pkg::ASCII_R;
            mcs_pkg::BYTE_M:      emit_byte = mcs_pkg::ASCII_M;
            mcs_pkg::BYTE_ROTDIR: emit_byte = rot_reg[mcs_pkg::FIELD_W-1] ?
                                              mcs_pkg::ASCII_L : mcs_pkg::ASCII_R;
            mcs_pkg::BYTE_MOVDIR: emit_byte = mov_reg[mcs_pkg::FIELD_W-1] ?
                                              mcs_pkg::ASCII_B : mcs_pkg::ASCII_F;
            mcs_pkg::BYTE_HUND:   emit_byte = mcs_pkg::ASCII_ZERO + {4'b0, hd};
            mcs_pkg::BYTE_TENS:   emit_byte = mcs_pkg::ASCII_ZERO + {4'b0, td};
            mcs_pkg::BYTE_ONES:   emit_byte = mcs_pkg::ASCII_ZERO + {4'b0, dig_reg[3:0]};
            mcs_pkg::BYTE_NL:     emit_byte = mcs_pkg::ASCII_NL;
            default:              emit_byte = mcs_pkg::ASCII_NL;
        endcase
    end

    always_comb begin
        unique case (cw.last)
            mcs_pkg::LAST_NO:         emit_last = 1'b0;
            mcs_pkg::LAST_YES:        emit_last = 1'b1;
            mcs_pkg::LAST_IF_NO_MOVE: emit_last = mov_zero;
            default:                  emit_last = 1'b0;
        endcase
    end

    always_comb begin
        unique case (cw.cond)
            mcs_pkg::COND_NEVER:      cond_true = 1'b0;
            mcs_pkg::COND_ALWAYS:     cond_true = 1'b1;
            mcs_pkg::COND_ROT_ZERO:   cond_true = rot_zero;
            mcs_pkg::COND_MOV_ZERO:   cond_true = mov_zero;
            mcs_pkg::COND_SPLIT_DONE: cond_true = split_done;
            default:                  cond_true = 1'b0;
        endcase
    end

    assign step_ok = (cw.op != mcs_pkg::OP_EMIT) || out_free;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        pc_next            = pc_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        count_next         = count_reg;
        turn_speed_next    = turn_speed_reg;
        speed_floor_next   = speed_floor_reg;
        speed_ceiling_next = speed_ceiling_reg;
        max_step_next      = max_step_reg;
        mag_next           = mag_reg;
        step_next          = step_reg;
        neg_next           = neg_reg;
        ang_next           = ang_reg;
        mov_next           = mov_reg;
        rot_next           = rot_reg;
        spd_q_next         = spd_q_reg;
        dig_next           = dig_reg;
        m_valid_next       = m_valid_reg;
        m_out_byte_next    = m_out_byte_reg;
        m_last_byte_next   = m_last_byte_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_accept) begin
            unique case (cfg_index)
                mcs_pkg::REG_TURN_SPEED:    turn_speed_next    = cfg_data;
                mcs_pkg::REG_SPEED_FLOOR:   speed_floor_next   = cfg_data;
                mcs_pkg::REG_SPEED_CEILING: speed_ceiling_next = cfg_data;
                mcs_pkg::REG_MAX_STEP_MM:   max_step_next      = cfg_data;
                default: ;
            endcase
        end

        unique case (cw.op)
            mcs_pkg::OP_IDLE: begin
                if (s_accept) begin
                    if (s_command) begin
                        if (!q_empty) begin
                            // pop; RAM read data arrives at the load step
                            head_next  = mcs_pkg::next_idx(head_reg);
                            count_next = count_reg - 1'b1;
                            pc_next    = mcs_pkg::PC_LOAD;
                        end
                    end else if (is_stop) begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end else begin
                        mag_next  = (mcs_pkg::MAG_W'(dist_abs) << 3) +
                                    (mcs_pkg::MAG_W'(dist_abs) << 1);
                        step_next = mcs_pkg::cap999({1'b0, (max_step_reg == '0) ?
                                                    mcs_pkg::CFG_W'(1) : max_step_reg});
                        neg_next  = s_distance_cm[mcs_pkg::FIELD_W-1];
                        ang_next  = s_turn_angle;
                        pc_next   = cw.jmp;
                    end
                end
            end
            mcs_pkg::OP_LOAD: begin
                mov_next = ram_rdata[mcs_pkg::FIELD_W-1:0];
                rot_next = ram_rdata[mcs_pkg::ENTRY_W-1:mcs_pkg::FIELD_W];
            end
            mcs_pkg::OP_CALC: begin
                spd_q_next = spd_prod[17:11];
            end
            mcs_pkg::OP_EMIT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_out_byte_next  = emit_byte;
                    m_last_byte_next = emit_last;
                    unique case (cw.dsel)
                        mcs_pkg::DIG_HOLD: dig_next = dig_reg;
                        mcs_pkg::DIG_HUND: dig_next = dig_reg - mcs_pkg::DIG_W'(hd) * 10'd100;
                        mcs_pkg::DIG_TENS: dig_next = dig_reg - mcs_pkg::DIG_W'(td) * 10'd10;
                        mcs_pkg::DIG_TURN: dig_next = mcs_pkg::cap999({1'b0, turn_speed_reg});
                        mcs_pkg::DIG_ROT:  dig_next = rot_mag;
                        mcs_pkg::DIG_SPD:  dig_next = spd_clamped;
                        mcs_pkg::DIG_MOV:  dig_next = mov_mag;
                        default:           dig_next = dig_reg;
                    endcase
                end
            end
            mcs_pkg::OP_SPLIT: begin
                if (!q_full) begin
                    tail_next  = mcs_pkg::next_idx(tail_reg);
                    count_next = count_reg + 1'b1;
                    if (split_more) begin
                        mag_next = mag_reg - mcs_pkg::MAG_W'(step_reg);
                    end
                end
            end
            mcs_pkg::OP_NOP: ;
            default: ;
        endcase

        // Sequencing for every word but the dispatch word
        if (cw.op != mcs_pkg::OP_IDLE && step_ok) begin
            priority if (cond_true) begin
                pc_next = cw.jmp;
            end else if (cw.rpt) begin
                pc_next = pc_reg;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg            <= mcs_pkg::PC_IDLE;
            head_reg          <= '0;
            tail_reg          <= '0;
            count_reg         <= '0;
            turn_speed_reg    <= mcs_pkg::TURN_SPEED_RST;
            speed_floor_reg   <= mcs_pkg::SPEED_FLOOR_RST;
            speed_ceiling_reg <= mcs_pkg::SPEED_CEILING_RST;
            max_step_reg      <= mcs_pkg::MAX_STEP_MM_RST;
            m_valid_reg       <= 1'b0;
        end else begin
            pc_reg            <= pc_next;
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            count_reg         <= count_next;
            turn_speed_reg    <= turn_speed_next;
            speed_floor_reg   <= speed_floor_next;
            speed_ceiling_reg <= speed_ceiling_next;
            max_step_reg      <= max_step_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        mag_reg         <= mag_next;
        step_reg        <= step_next;
        neg_reg         <= neg_next;
        ang_reg         <= ang_next;
        mov_reg         <= mov_next;
        rot_reg         <= rot_next;
        spd_q_reg       <= spd_q_next;
        dig_reg         <= dig_next;
        m_out_byte_reg  <= m_out_byte_next;
        m_last_byte_reg <= m_last_byte_next;
    end

endmodule

`default_nettype wire

// ===== hdl/mcs_checker.sv =====
// ============================================================================
// mcs_checker
// Port-level checks of the motion command serializer, bound to the top level.
// ============================================================================
`default_nettype none

module mcs_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       s_command,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_last_byte
);

    // Reset empties the byte stage and readies the input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("byte stage or input not idle after reset");

    // A stalled byte holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_byte))
        else $error("stalled byte changed");

    // The last byte of a stream is a newline
    a_last_is_nl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_byte |-> m_out_byte == mcs_pkg::ASCII_NL)
        else $error("final byte is not a newline");

    // Only command letters, digits and newline appear
    a_charset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_byte >= mcs_pkg::ASCII_ZERO && m_out_byte <= 8'h39) ||
                    m_out_byte == mcs_pkg::ASCII_R || m_out_byte == mcs_pkg::ASCII_L ||
                    m_out_byte == mcs_pkg::ASCII_M || m_out_byte == mcs_pkg::ASCII_F ||
                    m_out_byte == mcs_pkg::ASCII_B || m_out_byte == mcs_pkg::ASCII_NL)
        else $error("unexpected byte value");

    // A path element never starts a byte stream
    a_element_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_command && !m_valid |=> !m_valid)
        else $error("byte emitted after a path element");

endmodule

bind motion_command_serializer_core mcs_checker u_mcs_checker (.*);

`default_nettype wire
